FILE: hw/rtl/rvde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvde_pkg - shared types and codes for the RV32I decode and execute unit
// Word layouts on both channels, the decoded word passed from the front to
// the back, class, opcode and ALU operation codes, and default queue depths.
// ----------------------------------------------------------------------------
package rvde_pkg;

  // Default queue depths
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  // Result classes
  localparam logic [2:0] CLS_ALU    = 3'd0;
  localparam logic [2:0] CLS_LOAD   = 3'd1;
  localparam logic [2:0] CLS_STORE  = 3'd2;
  localparam logic [2:0] CLS_BRANCH = 3'd3;
  localparam logic [2:0] CLS_JUMP   = 3'd4;
  localparam logic [2:0] CLS_NONE   = 3'd5;

  // Major opcodes
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;

  // funct7 values defined by the base ISA
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] BR_EQ  = 3'd0;
  localparam logic [2:0] BR_NE  = 3'd1;
  localparam logic [2:0] BR_LT  = 3'd4;
  localparam logic [2:0] BR_GE  = 3'd5;
  localparam logic [2:0] BR_LTU = 3'd6;
  localparam logic [2:0] BR_GEU = 3'd7;

  localparam logic [2:0] LS_B  = 3'd0;
  localparam logic [2:0] LS_H  = 3'd1;
  localparam logic [2:0] LS_W  = 3'd2;
  localparam logic [2:0] LD_BU = 3'd4;
  localparam logic [2:0] LD_HU = 3'd5;

  localparam logic [2:0] JALR_F3 = 3'd0;

  // ALU operations
  localparam logic [3:0] ALU_ADD  = 4'd0;
  localparam logic [3:0] ALU_SUB  = 4'd1;
  localparam logic [3:0] ALU_SLL  = 4'd2;
  localparam logic [3:0] ALU_SLT  = 4'd3;
  localparam logic [3:0] ALU_SLTU = 4'd4;
  localparam logic [3:0] ALU_XOR  = 4'd5;
  localparam logic [3:0] ALU_SRL  = 4'd6;
  localparam logic [3:0] ALU_SRA  = 4'd7;
  localparam logic [3:0] ALU_OR   = 4'd8;
  localparam logic [3:0] ALU_AND  = 4'd9;

  typedef struct packed {
    logic        [31:0] instr;
    logic        [31:0] instr_pc;
    logic signed [31:0] rs1_value;
    logic signed [31:0] rs2_value;
    logic               predicted_taken;
  } in_item_t;

  typedef struct packed {
    logic        [2:0]  op_class;
    logic        [4:0]  dest_reg;
    logic               rd_write;
    logic signed [31:0] result_value;
    logic signed [31:0] store_value;
    logic        [1:0]  mem_size;
    logic               mem_signed;
    logic               branch_taken;
    logic               redirect;
    logic        [31:0] next_pc;
  } result_t;

  // Decoded word from front to back
  typedef struct packed {
    logic [2:0]  cls;
    logic [3:0]  alu_op;
    logic [31:0] opa;
    logic [31:0] opb;
    logic [31:0] pc;
    logic [31:0] tgt_base;
    logic [31:0] tgt_off;
    logic        clr_bit0;
    logic [2:0]  br_cond;
    logic        pred;
    logic [4:0]  rd;
    logic [31:0] sval;
    logic [1:0]  msize;
    logic        msigned;
  } dec_t;

endpackage

FILE: hw/rtl/rv32i_decode_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_decode_execute - RV32I decode and execute unit
// Decodes one instruction word per cycle while full is low and executes it: ALU and compare
// results, LUI/AUIPC values, link and load/store addresses, store data,
// branch outcome, redirect and next pc.
// ----------------------------------------------------------------------------
// Sustains one word per clock in each direction while full and empty are low.
// A pushed word is decoded into the middle queue, executed when the result
// queue has room, and written to the result queue to be popped. The two
// register queues (MID_DEPTH and OUT_DEPTH words) let the decoder keep
// taking words while results wait to be popped; full is the middle queue's
// full flag. No state beyond the queues.
module rv32i_decode_execute #(
  parameter int MID_DEPTH = rvde_pkg::MID_DEPTH,
  parameter int OUT_DEPTH = rvde_pkg::OUT_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  rvde_pkg::in_item_t item,
  input  logic               pop,
  output logic               empty,
  output rvde_pkg::result_t  result
);

  localparam int DEC_W = $bits(rvde_pkg::dec_t);
  localparam int RES_W = $bits(rvde_pkg::result_t);

  rvde_pkg::dec_t    dec_in;
  rvde_pkg::dec_t    dec_out;
  rvde_pkg::result_t res_in;
  logic              mid_empty;
  logic              out_full;
  logic              exec_fire;

  // Decode the incoming word
  rvde_front u_front (
    .item (item),
    .dec  (dec_in)
  );

  // Hold decoded words between front and back
  rvde_fifo #(
    .WIDTH (DEC_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (dec_in),
    .full  (full),
    .pop   (exec_fire),
    .rdata (dec_out),
    .empty (mid_empty)
  );

  // Execute the oldest decoded word when there is room for its result
  assign exec_fire = !mid_empty && !out_full;

  rvde_back u_back (
    .dec (dec_out),
    .res (res_in)
  );

  // Hold results until popped
  rvde_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (exec_fire),
    .wdata (res_in),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

`ifndef SYNTHESIS
  // A ready decoded word with room downstream must show up as a result
  a_exec_progress: assert property (@(posedge clk) disable iff (rst)
    (!mid_empty && !out_full) |=> !empty)
    else $error("executed word did not reach the result queue");

  // Only branches and jumps may redirect fetch
  a_redirect_class: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.redirect) |->
      (result.op_class == rvde_pkg::CLS_BRANCH ||
       result.op_class == rvde_pkg::CLS_JUMP))
    else $error("redirect from a non-control instruction");

  // Unknown encodings carry no result, no write and no redirect
  a_noop_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.op_class == rvde_pkg::CLS_NONE) |->
      (result.result_value == '0 && !result.rd_write && !result.redirect &&
       !result.branch_taken))
    else $error("no-op result carries side effects");

  // Stores never write the register file and always carry a valid size
  a_store_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.op_class == rvde_pkg::CLS_STORE) |->
      (!result.rd_write && ({1'b0, result.mem_size} <= rvde_pkg::LS_W) &&
       !result.mem_signed))
    else $error("malformed store result");
`endif

endmodule

FILE: hw/rtl/rvde_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvde_fifo - small register queue
// Holds up to DEPTH words in registers; full and empty come straight from
// the fill count, so both sides can stall on their own.
// ----------------------------------------------------------------------------
module rvde_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/rvde_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvde_front - instruction decoder
// Classifies one instruction word, builds its immediate, selects ALU
// operands and branch/jump target inputs, and flags unknown encodings.
// ----------------------------------------------------------------------------
module rvde_front (
  input  rvde_pkg::in_item_t item,
  output rvde_pkg::dec_t     dec
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_u;
  logic [31:0] imm_j;
  logic        f7_base;
  logic        f7_either;

  assign opc = item.instr[6:0];
  assign f3  = item.instr[14:12];
  assign f7  = item.instr[31:25];
  assign rd  = item.instr[11:7];

  assign f7_base   = (f7 == rvde_pkg::F7_BASE);
  assign f7_either = f7_base || (f7 == rvde_pkg::F7_ALT);

  // Build all immediate formats
  assign imm_i = {{20{item.instr[31]}}, item.instr[31:20]};
  assign imm_s = {{20{item.instr[31]}}, item.instr[31:25], item.instr[11:7]};
  assign imm_b = {{19{item.instr[31]}}, item.instr[31], item.instr[7],
                  item.instr[30:25], item.instr[11:8], 1'b0};
  assign imm_u = {item.instr[31:12], 12'b0};
  assign imm_j = {{11{item.instr[31]}}, item.instr[31], item.instr[19:12],
                  item.instr[20], item.instr[30:21], 1'b0};

  // Map funct3 and the alternate bit onto an ALU operation
  function automatic logic [3:0] alu_sel(input logic [2:0] fn, input logic alt);
    logic [3:0] op;
    begin
      case (fn)
        rvde_pkg::F3_ADD:  op = alt ? rvde_pkg::ALU_SUB : rvde_pkg::ALU_ADD;
        rvde_pkg::F3_SLL:  op = rvde_pkg::ALU_SLL;
        rvde_pkg::F3_SLT:  op = rvde_pkg::ALU_SLT;
        rvde_pkg::F3_SLTU: op = rvde_pkg::ALU_SLTU;
        rvde_pkg::F3_XOR:  op = rvde_pkg::ALU_XOR;
        rvde_pkg::F3_SR:   op = alt ? rvde_pkg::ALU_SRA : rvde_pkg::ALU_SRL;
        rvde_pkg::F3_OR:   op = rvde_pkg::ALU_OR;
        default:           op = rvde_pkg::ALU_AND;
      endcase
      return op;
    end
  endfunction

  // Decode the opcode group; anything not recognised stays a no-op
  always_comb begin
    dec          = '0;
    dec.cls      = rvde_pkg::CLS_NONE;
    dec.alu_op   = rvde_pkg::ALU_ADD;
    dec.pc       = item.instr_pc;
    dec.tgt_base = item.instr_pc;
    dec.pred     = item.predicted_taken;
    dec.br_cond  = f3;
    unique case (opc)
      rvde_pkg::OPC_OP_IMM: begin
        dec.opa = $unsigned(item.rs1_value);
        dec.opb = imm_i;
        if (f3 == rvde_pkg::F3_SLL) begin
          dec.alu_op = rvde_pkg::ALU_SLL;
          if (f7_base) dec.cls = rvde_pkg::CLS_ALU;
        end else if (f3 == rvde_pkg::F3_SR) begin
          dec.alu_op = alu_sel(f3, f7[5]);
          if (f7_either) dec.cls = rvde_pkg::CLS_ALU;
        end else begin
          dec.alu_op = alu_sel(f3, 1'b0);
          dec.cls    = rvde_pkg::CLS_ALU;
        end
      end
      rvde_pkg::OPC_OP: begin
        dec.opa    = $unsigned(item.rs1_value);
        dec.opb    = $unsigned(item.rs2_value);
        dec.alu_op = alu_sel(f3, f7[5]);
        if ((f3 == rvde_pkg::F3_ADD) || (f3 == rvde_pkg::F3_SR)) begin
          if (f7_either) dec.cls = rvde_pkg::CLS_ALU;
        end else if (f7_base) begin
          dec.cls = rvde_pkg::CLS_ALU;
        end
      end
      rvde_pkg::OPC_LUI: begin
        dec.cls = rvde_pkg::CLS_ALU;
        dec.opb = imm_u;
      end
      rvde_pkg::OPC_AUIPC: begin
        dec.cls = rvde_pkg::CLS_ALU;
        dec.opa = item.instr_pc;
        dec.opb = imm_u;
      end
      rvde_pkg::OPC_JAL: begin
        dec.cls     = rvde_pkg::CLS_JUMP;
        dec.tgt_off = imm_j;
      end
      rvde_pkg::OPC_JALR: begin
        if (f3 == rvde_pkg::JALR_F3) begin
          dec.cls      = rvde_pkg::CLS_JUMP;
          dec.tgt_base = $unsigned(item.rs1_value);
          dec.tgt_off  = imm_i;
          dec.clr_bit0 = 1'b1;
        end
      end
      rvde_pkg::OPC_BRANCH: begin
        dec.opa     = $unsigned(item.rs1_value);
        dec.opb     = $unsigned(item.rs2_value);
        dec.tgt_off = imm_b;
        if ((f3 != rvde_pkg::F3_SLT) && (f3 != rvde_pkg::F3_SLTU)) begin
          dec.cls = rvde_pkg::CLS_BRANCH;
        end
      end
      rvde_pkg::OPC_LOAD: begin
        if ((f3 == rvde_pkg::LS_B) || (f3 == rvde_pkg::LS_H) ||
            (f3 == rvde_pkg::LS_W) || (f3 == rvde_pkg::LD_BU) ||
            (f3 == rvde_pkg::LD_HU)) begin
          dec.cls     = rvde_pkg::CLS_LOAD;
          dec.opa     = $unsigned(item.rs1_value);
          dec.opb     = imm_i;
          dec.msize   = f3[1:0];
          dec.msigned = !f3[2];
        end
      end
      rvde_pkg::OPC_STORE: begin
        if ((f3 == rvde_pkg::LS_B) || (f3 == rvde_pkg::LS_H) ||
            (f3 == rvde_pkg::LS_W)) begin
          dec.cls   = rvde_pkg::CLS_STORE;
          dec.opa   = $unsigned(item.rs1_value);
          dec.opb   = imm_s;
          dec.sval  = $unsigned(item.rs2_value);
          dec.msize = f3[1:0];
        end
      end
      default: begin
        dec.cls = rvde_pkg::CLS_NONE;
      end
    endcase
    // Keep rd only for classes that write the register file
    if ((dec.cls == rvde_pkg::CLS_ALU) || (dec.cls == rvde_pkg::CLS_LOAD) ||
        (dec.cls == rvde_pkg::CLS_JUMP)) begin
      dec.rd = rd;
    end
  end

endmodule

FILE: hw/rtl/rvde_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvde_back - execute stage
// Runs the ALU, the branch compare and the target adder on one decoded
// word and assembles the result word.
// ----------------------------------------------------------------------------
module rvde_back (
  input  rvde_pkg::dec_t  dec,
  output rvde_pkg::result_t res
);

  logic [31:0] alu_out;
  logic [31:0] pc_plus4;
  logic [31:0] target;
  logic [4:0]  sh;
  logic        eq;
  logic        lt_s;
  logic        lt_u;
  logic        taken;

  assign sh       = dec.opb[4:0];
  assign eq       = (dec.opa == dec.opb);
  assign lt_s     = ($signed(dec.opa) < $signed(dec.opb));
  assign lt_u     = (dec.opa < dec.opb);
  assign pc_plus4 = dec.pc + 32'd4;
  assign target   = (dec.tgt_base + dec.tgt_off) & ~{31'b0, dec.clr_bit0};

  // ALU
  always_comb begin
    unique case (dec.alu_op)
      rvde_pkg::ALU_ADD:  alu_out = dec.opa + dec.opb;
      rvde_pkg::ALU_SUB:  alu_out = dec.opa - dec.opb;
      rvde_pkg::ALU_SLL:  alu_out = dec.opa << sh;
      rvde_pkg::ALU_SLT:  alu_out = {31'b0, lt_s};
      rvde_pkg::ALU_SLTU: alu_out = {31'b0, lt_u};
      rvde_pkg::ALU_XOR:  alu_out = dec.opa ^ dec.opb;
      rvde_pkg::ALU_SRL:  alu_out = dec.opa >> sh;
      rvde_pkg::ALU_SRA:  alu_out = $unsigned($signed(dec.opa) >>> sh);
      rvde_pkg::ALU_OR:   alu_out = dec.opa | dec.opb;
      rvde_pkg::ALU_AND:  alu_out = dec.opa & dec.opb;
      default:            alu_out = '0;
    endcase
  end

  // Branch condition
  always_comb begin
    unique case (dec.br_cond)
      rvde_pkg::BR_EQ:  taken = eq;
      rvde_pkg::BR_NE:  taken = !eq;
      rvde_pkg::BR_LT:  taken = lt_s;
      rvde_pkg::BR_GE:  taken = !lt_s;
      rvde_pkg::BR_LTU: taken = lt_u;
      rvde_pkg::BR_GEU: taken = !lt_u;
      default:          taken = 1'b0;
    endcase
  end

  // Assemble the result word by class
  always_comb begin
    res              = '0;
    res.op_class     = dec.cls;
    res.dest_reg     = dec.rd;
    res.rd_write     = (dec.rd != 5'd0);
    res.store_value  = $signed(dec.sval);
    res.mem_size     = dec.msize;
    res.mem_signed   = dec.msigned;
    res.next_pc      = pc_plus4;
    case (dec.cls) inside
      rvde_pkg::CLS_ALU, rvde_pkg::CLS_LOAD, rvde_pkg::CLS_STORE: begin
        res.result_value = $signed(alu_out);
      end
      rvde_pkg::CLS_JUMP: begin
        res.result_value = $signed(pc_plus4);
        res.branch_taken = 1'b1;
        res.redirect     = 1'b1;
        res.next_pc      = target;
      end
      rvde_pkg::CLS_BRANCH: begin
        res.branch_taken = taken;
        res.redirect     = taken ^ dec.pred;
        res.next_pc      = taken ? target : pc_plus4;
      end
      default: begin
        res.result_value = '0;
      end
    endcase
  end

endmodule
